### hw/rtl/qte_pkg.sv
// Shared types, constants and the arctangent table of the quaternion to Euler angle block.
package qte_pkg;

    // Working widths of the datapath.
    localparam int WIDE_W = 40;
    localparam int ANG_W  = 34;
    localparam int OPND_W = 34;
    localparam int PROD_W = 68;

    // Fixed-point constants in Q30.
    localparam logic signed [ANG_W-1:0]  PI_Q30  = 34'sd3373259426;
    localparam logic signed [WIDE_W-1:0] ONE_Q30 = 40'sd1073741824;

    // Scale from Q30 radians to centidegrees and the output limits.
    localparam logic signed [OPND_W-1:0] CENTIDEG_PER_RAD = 34'sd5730;
    localparam logic [17:0] PITCH_LIM = 18'd9001;
    localparam logic [17:0] ANGLE_LIM = 18'd18001;

    // Number of product terms and the top digit of the square root.
    localparam logic [4:0] NUM_TERMS = 5'd10;
    localparam logic [4:0] SQRT_TOP  = 5'd30;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQ,
        ST_SQ_LOAD,
        ST_SQRT,
        ST_ANG_LOAD,
        ST_ANG_RUN,
        ST_ROUND,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        TERM_WW,
        TERM_XX,
        TERM_YY,
        TERM_ZZ,
        TERM_WY,
        TERM_XZ,
        TERM_YZ,
        TERM_WX,
        TERM_XY,
        TERM_WZ
    } term_t;

    typedef enum logic [1:0] {
        ANG_PITCH,
        ANG_ROLL,
        ANG_YAW
    } angle_sel_t;

    // Request and response between the sequencer and the CORDIC unit.
    typedef struct packed {
        logic                     start;
        logic signed [WIDE_W-1:0] y;
        logic signed [WIDE_W-1:0] x;
    } cordic_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [ANG_W-1:0] angle;
    } cordic_resp_t;

    // Truncated atan(2^-i) in Q30 radians.
    function automatic logic [29:0] atan_entry(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:    v = 30'h3243F6A8;
            5'd1:    v = 30'h1DAC6705;
            5'd2:    v = 30'h0FADBAFC;
            5'd3:    v = 30'h07F56EA6;
            5'd4:    v = 30'h03FEAB76;
            5'd5:    v = 30'h01FFD55B;
            5'd6:    v = 30'h00FFFAAA;
            5'd7:    v = 30'h007FFF55;
            5'd8:    v = 30'h003FFFEA;
            5'd9:    v = 30'h001FFFFD;
            5'd10:   v = 30'h000FFFFF;
            5'd11:   v = 30'h0007FFFF;
            5'd12:   v = 30'h0003FFFF;
            5'd13:   v = 30'h0001FFFF;
            5'd14:   v = 30'h0000FFFF;
            5'd15:   v = 30'h00007FFF;
            5'd16:   v = 30'h00003FFF;
            5'd17:   v = 30'h00001FFF;
            5'd18:   v = 30'h00000FFF;
            5'd19:   v = 30'h000007FF;
            5'd20:   v = 30'h000003FF;
            5'd21:   v = 30'h000001FF;
            5'd22:   v = 30'h000000FF;
            5'd23:   v = 30'h0000007F;
            5'd24:   v = 30'h0000003F;
            5'd25:   v = 30'h0000001F;
            5'd26:   v = 30'h0000000F;
            5'd27:   v = 30'h00000008;
            5'd28:   v = 30'h00000004;
            5'd29:   v = 30'h00000002;
            5'd30:   v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/qte_if.sv
// Handshake interfaces for the quaternion input and the Euler angle output.
interface qte_quat_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic               has_quat;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, output has_quat, input ready);
    modport sink (input valid, input quat_w, input quat_x, input quat_y,
                  input quat_z, input has_quat, output ready);
endinterface

interface qte_euler_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] pitch_centideg;
    logic signed [15:0] roll_centideg;
    logic signed [15:0] yaw_centideg;
    logic               ok;

    modport source (output valid, output pitch_centideg, output roll_centideg,
                    output yaw_centideg, output ok, input ready);
    modport sink (input valid, input pitch_centideg, input roll_centideg,
                  input yaw_centideg, input ok, output ready);
endinterface

### hw/rtl/quaternion_to_euler_angles.sv
// Top level: converts a Q2.30 quaternion into pitch, roll and yaw in centidegrees.
//
// The quat channel carries one quaternion (w, x, y, z in signed Q2.30) and a
// has_quat flag per transaction. The euler channel returns one transaction per
// input: pitch, roll and yaw in hundredths of a degree and ok.
// With has_quat high the block forms ten products on a shared 34x34 multiplier,
// takes a 31-step square root for the asin cosine, and then runs one vectoring
// CORDIC unit three times, once per angle, followed by a scale and round.
// The CORDIC iterations and the square root digits set the time to a result.
// Without a quaternion the sequencer goes straight to its finishing state and
// the held angles come back with ok low.
// The block takes one transaction at a time: quat.ready is high only while the
// sequencer is idle, so a new quaternion is accepted only once the last one has
// left the finishing step. A finished result sits in an output register, so
// a new transaction is accepted while the receiver still stalls; the next result
// then waits, and the block stays busy, until the register is taken.
// Reset clears the held angles to zero and empties the output register.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STEPS = 24
) (
    input logic         clk,
    input logic         rst_n,
    qte_quat_if.sink    quat,
    qte_euler_if.source euler
);
    import qte_pkg::*;

    state_t                   state_reg, state_next;
    logic [4:0]               cnt_reg, cnt_next;
    term_t                    term_reg, term_next;
    angle_sel_t               ang_reg, ang_next;
    logic signed [31:0]       qw_reg, qw_next;
    logic signed [31:0]       qx_reg, qx_next;
    logic signed [31:0]       qy_reg, qy_next;
    logic signed [31:0]       qz_reg, qz_next;
    logic                     ok_reg, ok_next;
    logic signed [WIDE_W-1:0] acc_s_reg, acc_s_next;
    logic signed [WIDE_W-1:0] acc_ry_reg, acc_ry_next;
    logic signed [WIDE_W-1:0] acc_rx_reg, acc_rx_next;
    logic signed [WIDE_W-1:0] acc_yy_reg, acc_yy_next;
    logic signed [WIDE_W-1:0] acc_yx_reg, acc_yx_next;
    logic signed [31:0]       s_reg, s_next;
    logic [61:0]              n_reg, n_next;
    logic [61:0]              root_reg, root_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     neg_reg, neg_next;
    logic signed [14:0]       held_pitch_reg, held_pitch_next;
    logic signed [15:0]       held_roll_reg, held_roll_next;
    logic signed [15:0]       held_yaw_reg, held_yaw_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [14:0]       out_pitch_reg, out_pitch_next;
    logic signed [15:0]       out_roll_reg, out_roll_next;
    logic signed [15:0]       out_yaw_reg, out_yaw_next;
    logic                     out_ok_reg, out_ok_next;

    logic signed [OPND_W-1:0] mul_a;
    logic signed [OPND_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [WIDE_W-1:0] mq;
    logic signed [WIDE_W-1:0] s2;
    logic signed [31:0]       s_cl;
    logic [61:0]              bitv;
    logic [61:0]              trial;
    logic signed [ANG_W-1:0]  mag;
    logic [47:0]              rnd;
    logic [17:0]              r_sat;
    logic [17:0]              lim;
    logic signed [15:0]       ang16;
    term_t                    term_cur;
    cordic_req_t              creq;
    cordic_resp_t             cresp;

    function automatic logic signed [OPND_W-1:0] sx32(input logic signed [31:0] v);
        return {{(OPND_W-32){v[31]}}, v};
    endfunction

    qte_cordic #(
        .STEPS(CORDIC_STEPS)
    ) u_cordic (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (creq),
        .resp (cresp)
    );

    // Shared multiplier and the floored Q30 product of the previous cycle.
    assign mul_p = mul_a * mul_b;
    assign mq    = {{(WIDE_W-34){prod_reg[63]}}, prod_reg[63:30]};

    // Doubled asin argument, clamped to plus or minus one.
    assign s2 = acc_s_reg <<< 1;
    always_comb
    begin
        if (s2 > ONE_Q30)
            s_cl = 32'(ONE_Q30);
        else if (s2 < -ONE_Q30)
            s_cl = 32'(-ONE_Q30);
        else
            s_cl = 32'(s2);
    end

    // Square root digit and its trial subtrahend.
    assign bitv  = 62'(1) << {cnt_reg, 1'b0};
    assign trial = root_reg + bitv;

    // Magnitude of the angle, rounding and saturation for the current output.
    assign term_cur = term_t'(cnt_reg[3:0]);
    assign mag      = (cresp.angle < 0) ? -cresp.angle : cresp.angle;
    assign rnd      = {1'b0, prod_reg[46:0]} + (48'd1 << 29);
    assign lim      = (ang_reg == ANG_PITCH) ? PITCH_LIM : ANGLE_LIM;
    assign r_sat    = (rnd[47:30] > lim) ? lim : rnd[47:30];
    assign ang16    = neg_reg ? -$signed(r_sat[15:0]) : $signed(r_sat[15:0]);

    // Sequencer: next state and datapath control.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        term_next       = term_reg;
        ang_next        = ang_reg;
        qw_next         = qw_reg;
        qx_next         = qx_reg;
        qy_next         = qy_reg;
        qz_next         = qz_reg;
        ok_next         = ok_reg;
        acc_s_next      = acc_s_reg;
        acc_ry_next     = acc_ry_reg;
        acc_rx_next     = acc_rx_reg;
        acc_yy_next     = acc_yy_reg;
        acc_yx_next     = acc_yx_reg;
        s_next          = s_reg;
        n_next          = n_reg;
        root_next       = root_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        held_pitch_next = held_pitch_reg;
        held_roll_next  = held_roll_reg;
        held_yaw_next   = held_yaw_reg;
        out_valid_next  = out_valid_reg && !euler.ready;
        out_pitch_next  = out_pitch_reg;
        out_roll_next   = out_roll_reg;
        out_yaw_next    = out_yaw_reg;
        out_ok_next     = out_ok_reg;
        mul_a           = '0;
        mul_b           = '0;
        creq            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (quat.valid)
                begin
                    qw_next     = quat.quat_w;
                    qx_next     = quat.quat_x;
                    qy_next     = quat.quat_y;
                    qz_next     = quat.quat_z;
                    ok_next     = quat.has_quat;
                    acc_s_next  = '0;
                    acc_ry_next = '0;
                    acc_rx_next = '0;
                    acc_yy_next = '0;
                    acc_yx_next = '0;
                    cnt_next    = '0;
                    state_next  = quat.has_quat ? ST_MUL : ST_FINISH;
                end
            end

            ST_MUL:
            begin
                // Multiply term cnt while accumulating the term of the last cycle.
                unique case (term_cur)
                    TERM_WW: begin mul_a = sx32(qw_reg); mul_b = sx32(qw_reg); end
                    TERM_XX: begin mul_a = sx32(qx_reg); mul_b = sx32(qx_reg); end
                    TERM_YY: begin mul_a = sx32(qy_reg); mul_b = sx32(qy_reg); end
                    TERM_ZZ: begin mul_a = sx32(qz_reg); mul_b = sx32(qz_reg); end
                    TERM_WY: begin mul_a = sx32(qw_reg); mul_b = sx32(qy_reg); end
                    TERM_XZ: begin mul_a = sx32(qx_reg); mul_b = sx32(qz_reg); end
                    TERM_YZ: begin mul_a = sx32(qy_reg); mul_b = sx32(qz_reg); end
                    TERM_WX: begin mul_a = sx32(qw_reg); mul_b = sx32(qx_reg); end
                    TERM_XY: begin mul_a = sx32(qx_reg); mul_b = sx32(qy_reg); end
                    TERM_WZ: begin mul_a = sx32(qw_reg); mul_b = sx32(qz_reg); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
                prod_next = mul_p;
                term_next = term_cur;
                if (cnt_reg != '0)
                begin
                    unique case (term_reg)
                        TERM_WW: acc_yx_next = acc_yx_reg + mq;
                        TERM_XX:
                        begin
                            acc_rx_next = acc_rx_reg + mq;
                            acc_yx_next = acc_yx_reg + mq;
                        end
                        TERM_YY:
                        begin
                            acc_rx_next = acc_rx_reg + mq;
                            acc_yx_next = acc_yx_reg - mq;
                        end
                        TERM_ZZ: acc_yx_next = acc_yx_reg - mq;
                        TERM_WY: acc_s_next  = acc_s_reg + mq;
                        TERM_XZ: acc_s_next  = acc_s_reg - mq;
                        TERM_YZ: acc_ry_next = acc_ry_reg + mq;
                        TERM_WX: acc_ry_next = acc_ry_reg + mq;
                        TERM_XY: acc_yy_next = acc_yy_reg + mq;
                        TERM_WZ: acc_yy_next = acc_yy_reg + mq;
                        default: acc_s_next  = acc_s_reg;
                    endcase
                end
                if (cnt_reg == NUM_TERMS)
                    state_next = ST_SQ;
                else
                    cnt_next = cnt_reg + 1'b1;
            end

            ST_SQ:
            begin
                mul_a      = sx32(s_cl);
                mul_b      = sx32(s_cl);
                prod_next  = mul_p;
                s_next     = s_cl;
                state_next = ST_SQ_LOAD;
            end

            ST_SQ_LOAD:
            begin
                n_next     = (62'(1) << 60) - 62'(prod_reg[61:0]);
                root_next  = '0;
                cnt_next   = SQRT_TOP;
                state_next = ST_SQRT;
            end

            ST_SQRT:
            begin
                // One base-4 digit of the integer square root per cycle.
                if (n_reg >= trial)
                begin
                    n_next    = n_reg - trial;
                    root_next = (root_reg >> 1) + bitv;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                if (cnt_reg == '0)
                begin
                    ang_next   = ANG_PITCH;
                    state_next = ST_ANG_LOAD;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            ST_ANG_LOAD:
            begin
                creq.start = 1'b1;
                unique case (ang_reg)
                    ANG_PITCH:
                    begin
                        creq.y = {{(WIDE_W-32){s_reg[31]}}, s_reg};
                        creq.x = {{(WIDE_W-31){1'b0}}, root_reg[30:0]};
                    end
                    ANG_ROLL:
                    begin
                        creq.y = acc_ry_reg <<< 1;
                        creq.x = ONE_Q30 - (acc_rx_reg <<< 1);
                    end
                    ANG_YAW:
                    begin
                        creq.y = acc_yy_reg <<< 1;
                        creq.x = acc_yx_reg;
                    end
                    default:
                    begin
                        creq.y = '0;
                        creq.x = '0;
                    end
                endcase
                state_next = ST_ANG_RUN;
            end

            ST_ANG_RUN:
            begin
                if (cresp.done)
                begin
                    mul_a      = mag;
                    mul_b      = CENTIDEG_PER_RAD;
                    prod_next  = mul_p;
                    neg_next   = (cresp.angle < 0);
                    state_next = ST_ROUND;
                end
            end

            ST_ROUND:
            begin
                unique case (ang_reg)
                    ANG_PITCH:
                    begin
                        held_pitch_next = ang16[14:0];
                        ang_next        = ANG_ROLL;
                        state_next      = ST_ANG_LOAD;
                    end
                    ANG_ROLL:
                    begin
                        held_roll_next = ang16;
                        ang_next       = ANG_YAW;
                        state_next     = ST_ANG_LOAD;
                    end
                    default:
                    begin
                        held_yaw_next = ang16;
                        state_next    = ST_FINISH;
                    end
                endcase
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || euler.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pitch_next = held_pitch_reg;
                    out_roll_next  = held_roll_reg;
                    out_yaw_next   = held_yaw_reg;
                    out_ok_next    = ok_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            term_reg       <= TERM_WW;
            ang_reg        <= ANG_PITCH;
            ok_reg         <= 1'b0;
            held_pitch_reg <= '0;
            held_roll_reg  <= '0;
            held_yaw_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            term_reg       <= term_next;
            ang_reg        <= ang_next;
            ok_reg         <= ok_next;
            held_pitch_reg <= held_pitch_next;
            held_roll_reg  <= held_roll_next;
            held_yaw_reg   <= held_yaw_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        qw_reg        <= qw_next;
        qx_reg        <= qx_next;
        qy_reg        <= qy_next;
        qz_reg        <= qz_next;
        acc_s_reg     <= acc_s_next;
        acc_ry_reg    <= acc_ry_next;
        acc_rx_reg    <= acc_rx_next;
        acc_yy_reg    <= acc_yy_next;
        acc_yx_reg    <= acc_yx_next;
        s_reg         <= s_next;
        n_reg         <= n_next;
        root_reg      <= root_next;
        prod_reg      <= prod_next;
        neg_reg       <= neg_next;
        out_pitch_reg <= out_pitch_next;
        out_roll_reg  <= out_roll_next;
        out_yaw_reg   <= out_yaw_next;
        out_ok_reg    <= out_ok_next;
    end

    // Channel outputs.
    assign quat.ready           = (state_reg == ST_IDLE);
    assign euler.valid          = out_valid_reg;
    assign euler.pitch_centideg = out_pitch_reg;
    assign euler.roll_centideg  = out_roll_reg;
    assign euler.yaw_centideg   = out_yaw_reg;
    assign euler.ok             = out_ok_reg;

    // A result appears only from the finishing step of the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(euler.valid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside the finishing step");

    // The CORDIC unit answers only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cresp.done |-> (state_reg == ST_ANG_RUN))
        else $error("CORDIC done while not waiting");

    // An accepted transaction always moves the sequencer out of idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (quat.valid && quat.ready) |=> (state_reg != ST_IDLE))
        else $error("accepted transaction left the sequencer idle");

    // The pitch shown never exceeds its saturation limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        euler.valid |-> (euler.pitch_centideg <= 15'sd9001 &&
                         euler.pitch_centideg >= -15'sd9001))
        else $error("pitch beyond its limit");

endmodule

### hw/rtl/qte_cordic.sv
// Vectoring CORDIC unit that returns atan2(y, x) in Q30 radians, one step per cycle.
module qte_cordic #(
    parameter int STEPS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  qte_pkg::cordic_req_t  req,
    output qte_pkg::cordic_resp_t resp
);
    import qte_pkg::*;

    localparam int STEP_W = $clog2(STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    logic signed [WIDE_W-1:0] x_reg, x_next;
    logic signed [WIDE_W-1:0] y_reg, y_next;
    logic signed [ANG_W-1:0]  z_reg, z_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    logic signed [WIDE_W-1:0] dx;
    logic signed [WIDE_W-1:0] dy;
    logic signed [ANG_W-1:0]  at;

    // Shifted copies and the table angle for the current step.
    assign dx = x_reg >>> step_reg;
    assign dy = y_reg >>> step_reg;
    assign at = $signed({4'b0000, atan_entry(5'(step_reg))});

    // Load on start (answering directly when y is zero), then rotate toward the x axis until the last step.
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            step_next = '0;
            if (req.y == '0)
            begin
                z_next    = (req.x < 0) ? PI_Q30 : '0;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (req.x < 0)
            begin
                x_next    = -req.x;
                y_next    = -req.y;
                z_next    = (req.y > 0) ? PI_Q30 : -PI_Q30;
                busy_next = 1'b1;
            end
            else
            begin
                x_next    = req.x;
                y_next    = req.y;
                z_next    = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (!y_reg[WIDE_W-1])
            begin
                x_next = x_reg + dy;
                y_next = y_reg - dx;
                z_next = z_reg + at;
            end
            else
            begin
                x_next = x_reg - dy;
                y_next = y_reg + dx;
                z_next = z_reg - at;
            end
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign resp.done  = done_reg;
    assign resp.angle = z_reg;

endmodule

### tb/tb_quaternion_to_euler_angles.sv
// Self-checking testbench for the quaternion to Euler angle converter.
module tb_quaternion_to_euler_angles;

    // Input transaction waiting to be driven; hold_back waits for an empty pipeline.
    typedef struct {
        logic signed [31:0] w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               has;
        bit                 hold_back;
    } quat_item_t;

    // Expected angles of one result transaction.
    typedef struct {
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
        logic signed [15:0] yaw;
        logic               ok;
    } euler_angles_t;

    localparam longint Q30_ONE    = 64'sd1073741824;
    localparam longint Q30_PI     = 64'sd3373259426;
    localparam int     STEPS      = 24;
    localparam int     PITCH_SAT  = 9001;
    localparam int     ANGLE_SAT  = 18001;

    // Idle pattern of each phase.
    typedef enum int {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } idle_phase_t;

    logic clk;
    logic rst_n;

    qte_quat_if  quat_ch();
    qte_euler_if euler_ch();

    quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .quat  (quat_ch),
        .euler (euler_ch)
    );

    quat_item_t    quat_pending[$];
    euler_angles_t angles_due[$];
    idle_phase_t   phase;
    bit            failed;

    // Held angles of the predictor.
    logic signed [14:0] pitch_held;
    logic signed [15:0] roll_held;
    logic signed [15:0] yaw_held;

    longint atan_lut [32] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
        'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
        'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
        'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
        'h00000001, 'h00000000
    };

    // Clock and a single reset pulse.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Q30 product with floor rounding.
    function automatic longint q30_mul(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    // Integer square root, digit by digit.
    function automatic longint floor_root(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return longint'(root);
    endfunction

    // Vectoring CORDIC arctangent in Q30 radians.
    function automatic longint cordic_atan2(longint ys, longint xs);
        longint acc;
        longint dx;
        longint dy;
        acc = 0;
        if (ys == 0)
            return (xs < 0) ? Q30_PI : 0;
        if (xs < 0)
        begin
            acc = (ys > 0) ? Q30_PI : -Q30_PI;
            xs = -xs;
            ys = -ys;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = xs >>> i;
            dy = ys >>> i;
            if (ys >= 0)
            begin
                xs += dy;
                ys -= dx;
                acc += atan_lut[i];
            end
            else
            begin
                xs -= dy;
                ys += dx;
                acc -= atan_lut[i];
            end
        end
        return acc;
    endfunction

    // Q30 radians to rounded, saturated centidegrees.
    function automatic int to_centideg(longint ang, int lim);
        longint unsigned mag;
        longint          r;
        mag = (ang < 0) ? longint'(-ang) : longint'(ang);
        r = longint'((mag * 64'd5730 + (64'd1 << 29)) >> 30);
        if (r > lim)
            r = lim;
        return (ang < 0) ? -int'(r) : int'(r);
    endfunction

    // Expected angles for one accepted quaternion transaction.
    function automatic euler_angles_t predict_angles(quat_item_t it);
        euler_angles_t res;
        longint w, x, y, z;
        longint sn, cs, ry, rx, wy2, wx2;
        if (it.has)
        begin
            w = it.w;
            x = it.x;
            y = it.y;
            z = it.z;
            sn  = 2 * (q30_mul(w, y) - q30_mul(x, z));
            ry  = 2 * (q30_mul(y, z) + q30_mul(w, x));
            rx  = Q30_ONE - 2 * (q30_mul(x, x) + q30_mul(y, y));
            wy2 = 2 * (q30_mul(x, y) + q30_mul(w, z));
            wx2 = q30_mul(w, w) + q30_mul(x, x) - q30_mul(y, y) - q30_mul(z, z);
            if (sn > Q30_ONE)
                sn = Q30_ONE;
            if (sn < -Q30_ONE)
                sn = -Q30_ONE;
            cs = floor_root(longint'(Q30_ONE * Q30_ONE - sn * sn));
            pitch_held = 15'(to_centideg(cordic_atan2(sn, cs), PITCH_SAT));
            roll_held  = 16'(to_centideg(cordic_atan2(ry, rx), ANGLE_SAT));
            yaw_held   = 16'(to_centideg(cordic_atan2(wy2, wx2), ANGLE_SAT));
        end
        res.pitch = pitch_held;
        res.roll  = roll_held;
        res.yaw   = yaw_held;
        res.ok    = it.has;
        return res;
    endfunction

    function automatic quat_item_t make_quat(int w, int x, int y, int z, bit has);
        quat_item_t it;
        it.w = w;
        it.x = x;
        it.y = y;
        it.z = z;
        it.has = has;
        it.hold_back = 1'b0;
        return it;
    endfunction

    // Random component: full range, unit range, near zero or exactly plus or minus one.
    function automatic int rand_part();
        case ($urandom_range(3))
            0: return int'($urandom);
            1: return int'($urandom_range(32'h7FFF_FFFF)) - 32'sh4000_0000 +
                   int'($urandom_range(1)) * 0;
            2: return int'($urandom_range(2048)) - 1024;
            default: return ($urandom_range(1) != 0) ? 32'sh4000_0000 : -32'sh4000_0000;
        endcase
    endfunction

    // Roughly normalized random quaternion.
    function automatic quat_item_t rand_unit();
        int  c [4];
        real n;
        for (int k = 0; k < 4; k++)
            c[k] = int'($urandom_range(2000)) - 1000;
        n = $sqrt(real'(c[0] * c[0] + c[1] * c[1] + c[2] * c[2] + c[3] * c[3])) + 1.0;
        return make_quat(int'(c[0] * 1073741824.0 / n), int'(c[1] * 1073741824.0 / n),
                         int'(c[2] * 1073741824.0 / n), int'(c[3] * 1073741824.0 / n), 1'b1);
    endfunction

    // Driver: presents the queue head and records expectations on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        bit idle_now;
        if (!rst_n)
        begin
            quat_ch.valid    <= 1'b0;
            quat_ch.quat_w   <= '0;
            quat_ch.quat_x   <= '0;
            quat_ch.quat_y   <= '0;
            quat_ch.quat_z   <= '0;
            quat_ch.has_quat <= 1'b0;
        end
        else
        begin
            if (quat_ch.valid && quat_ch.ready)
            begin
                angles_due.push_back(predict_angles(quat_pending[0]));
                void'(quat_pending.pop_front());
            end
            if (!(quat_ch.valid && !quat_ch.ready))
            begin
                case (phase)
                    PH_SEND_IDLE: idle_now = ($urandom_range(99) < 88);
                    PH_BOTH:      idle_now = ($urandom_range(99) < 23);
                    default:      idle_now = 1'b0;
                endcase
                if (quat_pending.size() != 0 && !idle_now &&
                    (!quat_pending[0].hold_back || angles_due.size() == 0))
                begin
                    quat_ch.valid    <= 1'b1;
                    quat_ch.quat_w   <= quat_pending[0].w;
                    quat_ch.quat_x   <= quat_pending[0].x;
                    quat_ch.quat_y   <= quat_pending[0].y;
                    quat_ch.quat_z   <= quat_pending[0].z;
                    quat_ch.has_quat <= quat_pending[0].has;
                end
                else
                    quat_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure and a field-by-field check of each result.
    always @(posedge clk or negedge rst_n)
    begin
        euler_angles_t exp_a;
        if (!rst_n)
            euler_ch.ready <= 1'b0;
        else
        begin
            if (euler_ch.valid && euler_ch.ready)
            begin
                if (angles_due.size() == 0)
                begin
                    $display("%0t: unexpected result pitch=%0d roll=%0d yaw=%0d ok=%0b",
                             $time, euler_ch.pitch_centideg, euler_ch.roll_centideg,
                             euler_ch.yaw_centideg, euler_ch.ok);
                    failed = 1'b1;
                end
                else
                begin
                    exp_a = angles_due.pop_front();
                    if (euler_ch.pitch_centideg !== exp_a.pitch)
                    begin
                        $display("%0t: pitch expected %0d actual %0d", $time, exp_a.pitch,
                                 euler_ch.pitch_centideg);
                        failed = 1'b1;
                    end
                    if (euler_ch.roll_centideg !== exp_a.roll)
                    begin
                        $display("%0t: roll expected %0d actual %0d", $time, exp_a.roll,
                                 euler_ch.roll_centideg);
                        failed = 1'b1;
                    end
                    if (euler_ch.yaw_centideg !== exp_a.yaw)
                    begin
                        $display("%0t: yaw expected %0d actual %0d", $time, exp_a.yaw,
                                 euler_ch.yaw_centideg);
                        failed = 1'b1;
                    end
                    if (euler_ch.ok !== exp_a.ok)
                    begin
                        $display("%0t: ok expected %0b actual %0b", $time, exp_a.ok,
                                 euler_ch.ok);
                        failed = 1'b1;
                    end
                end
            end
            case (phase)
                PH_RECV_STALL: euler_ch.ready <= ($urandom_range(99) >= 88);
                PH_BOTH:       euler_ch.ready <= ($urandom_range(99) >= 23);
                default:       euler_ch.ready <= 1'b1;
            endcase
        end
    end

    // Stimulus: directed cases, then random transactions over the idle phases.
    initial
    begin
        quat_item_t it;
        failed = 1'b0;
        phase = PH_FREE;
        pitch_held = '0;
        roll_held = '0;
        yaw_held = '0;

        // Held zeros before any quaternion, identity, and all-zero parts.
        quat_pending.push_back(make_quat(5, -7, 9, 11, 1'b0));
        quat_pending.push_back(make_quat(32'sh4000_0000, 0, 0, 0, 1'b1));
        quat_pending.push_back(make_quat(0, 0, 0, 0, 1'b1));
        // Asin argument clamped high and low.
        quat_pending.push_back(make_quat(32'sh4000_0000, 0, 32'sh4000_0000, 0, 1'b1));
        quat_pending.push_back(make_quat(32'sh4000_0000, 0, -32'sh4000_0000, 0, 1'b1));
        quat_pending.push_back(make_quat(0, 32'sh4000_0000, 0, 32'sh4000_0000, 1'b1));
        // Zero sine with negative cosine gives pi for roll and yaw.
        quat_pending.push_back(make_quat(0, 32'sh4000_0000, 0, 0, 1'b1));
        quat_pending.push_back(make_quat(0, 0, 32'sh4000_0000, 0, 1'b1));
        quat_pending.push_back(make_quat(0, 0, 0, 32'sh4000_0000, 1'b1));
        // Field extremes, unnormalized.
        quat_pending.push_back(make_quat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                         32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1));
        quat_pending.push_back(make_quat(32'sh8000_0000, 32'sh8000_0000,
                                         32'sh8000_0000, 32'sh8000_0000, 1'b1));
        quat_pending.push_back(make_quat(32'sh7FFF_FFFF, 32'sh8000_0000,
                                         32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1));
        quat_pending.push_back(make_quat(32'sh8000_0000, 32'sh7FFF_FFFF,
                                         32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1));
        quat_pending.push_back(make_quat(-1, -1, -1, -1, 1'b1));
        quat_pending.push_back(make_quat(-1, -1, -1, -1, 1'b0));
        quat_pending.push_back(make_quat(32'sh2D41_3CCD, 0, 0, 32'sh2D41_3CCD, 1'b1));
        quat_pending.push_back(make_quat(32'sh2D41_3CCD, -32'sh2D41_3CCD, 0, 0, 1'b1));
        quat_pending.push_back(make_quat(0, 0, 0, 0, 1'b0));
        wait (quat_pending.size() == 0);

        // Random part, one block per idle pattern.
        for (int p = 0; p < 4; p++)
        begin
            phase = idle_phase_t'(p);
            for (int n = 0; n < 380; n++)
            begin
                if ($urandom_range(9) < 6)
                    it = rand_unit();
                else
                    it = make_quat(rand_part(), rand_part(), rand_part(), rand_part(), 1'b1);
                if ($urandom_range(9) == 0)
                    it.has = 1'b0;
                // Pause the sender until the pipeline has drained.
                it.hold_back = (n == 100);
                quat_pending.push_back(it);
            end
            wait (quat_pending.size() == 0);
        end

        @(posedge clk);
        wait (angles_due.size() == 0);
        repeat (200) @(posedge clk);
        if (!failed)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog on the whole run.
    initial
    begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
